// ----- design/voa_pkg.sv -----
// ----------------------------------------------------------------------------
// voa_pkg
// shared constants, codes and types of the voice allocator
// ----------------------------------------------------------------------------
package voa_pkg;

   localparam int VOICES    = 32;
   localparam int TIME_BITS = 48;
   localparam int IDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int GRP_W     = 8;
   localparam int TAG_W     = 8;
   localparam int FIN_W     = 5;
   localparam int OFFS_W    = 16;
   localparam int OUT_IDX_W = 5;
   localparam int MASK_W    = 32;
   // wide enough for both a finished-voice number and a cell index
   localparam int CMP_W     = (IDX_W > FIN_W) ? IDX_W + 1 : FIN_W + 1;

   // operation codes
   localparam logic [1:0] OP_TRIGGER  = 2'd0;
   localparam logic [1:0] OP_FINISHED = 2'd1;
   localparam logic [1:0] OP_SIL_TAG  = 2'd2;
   localparam logic [1:0] OP_SIL_ALL  = 2'd3;

   // candidate ranks, lower wins
   localparam logic [1:0] RANK_FREE  = 2'd0;
   localparam logic [1:0] RANK_OTHER = 2'd1;
   localparam logic [1:0] RANK_SAME  = 2'd2;

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [TIME_BITS-1:0] time_type;

   // running best voice handed along the row
   typedef struct packed {
      logic       valid;
      logic [1:0] rank;
      idx_type    idx;
      time_type   start;
   } cand_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic             clear_all;
      logic             clear_tag;
      logic             clear_fin;
      logic             clear_cut;
      logic [TAG_W-1:0] tag;
      logic [FIN_W-1:0] fin;
      logic [GRP_W-1:0] grp;
      logic             write_en;
      idx_type          write_idx;
      time_type         start;
   } cmd_type;

endpackage

// ----- design/voa_if.sv -----
// ----------------------------------------------------------------------------
// voa_req_if / voa_rsp_if
// valid/ready channels for events and allocation results
// ----------------------------------------------------------------------------
interface voa_req_if
   import voa_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               operation;
   logic                     sample_found;
   logic signed [GRP_W-1:0]  cut_group;
   logic [TIME_BITS-1:0]     current_time;
   logic [OFFS_W-1:0]        sample_offset;
   logic signed [TAG_W-1:0]  slot_tag;
   logic [FIN_W-1:0]         finished_voice;

   modport source (
      output valid, operation, sample_found, cut_group, current_time,
             sample_offset, slot_tag, finished_voice,
      input  ready
   );
   modport sink (
      input  valid, operation, sample_found, cut_group, current_time,
             sample_offset, slot_tag, finished_voice,
      output ready
   );
endinterface

interface voa_rsp_if
   import voa_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 accepted;
   logic [OUT_IDX_W-1:0] voice_index;
   logic                 stolen;
   logic [MASK_W-1:0]    freed_mask;

   modport source (
      output valid, accepted, voice_index, stolen, freed_mask,
      input  ready
   );
   modport sink (
      input  valid, accepted, voice_index, stolen, freed_mask,
      output ready
   );
endinterface

// ----- design/voa_cell.sv -----
// ----------------------------------------------------------------------------
// voa_cell
// one voice: its state, its silencing match and one stage of the search row
// ----------------------------------------------------------------------------
module voa_cell
   import voa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  idx_type  my_index,
   input  cmd_type  cmd,
   input  cand_type cand_in,
   output cand_type cand_out,
   output logic     freed
);

   logic             playing_ff, playing_in;
   logic [GRP_W-1:0] grp_ff;
   logic [TAG_W-1:0] tag_ff;
   time_type         start_ff;
   cand_type         cand_ff, cand_in_next;
   logic             clear;
   logic             write_me;
   logic [1:0]       my_rank;
   logic             take_mine;

   always_comb begin
      clear = cmd.clear_all
            | (cmd.clear_tag & (tag_ff == cmd.tag))
            | (cmd.clear_fin & (CMP_W'(cmd.fin) == CMP_W'(my_index)))
            | (cmd.clear_cut & playing_ff & (grp_ff == cmd.grp));
      freed    = playing_ff & clear;
      write_me = cmd.write_en & (cmd.write_idx == my_index);
   end

   always_comb begin
      playing_in = playing_ff;
      if (clear) begin
         playing_in = 1'b0;
      end
      if (write_me) begin
         playing_in = 1'b1;
      end
   end

   // search stage: keep the incoming candidate unless this voice beats it
   always_comb begin
      if (!playing_ff) begin
         my_rank = RANK_FREE;
      end else if (grp_ff != cmd.grp) begin
         my_rank = RANK_OTHER;
      end else begin
         my_rank = RANK_SAME;
      end
      take_mine = !cand_in.valid
                | (my_rank < cand_in.rank)
                | ((my_rank == cand_in.rank) & (my_rank != RANK_FREE)
                   & (start_ff < cand_in.start));
      if (take_mine) begin
         cand_in_next.valid = 1'b1;
         cand_in_next.rank  = my_rank;
         cand_in_next.idx   = my_index;
         cand_in_next.start = start_ff;
      end else begin
         cand_in_next = cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         cand_ff    <= '0;
      end else begin
         playing_ff <= playing_in;
         cand_ff    <= cand_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (write_me) begin
         grp_ff   <= cmd.grp;
         tag_ff   <= cmd.tag;
         start_ff <= cmd.start;
      end
   end

   assign cand_out = cand_ff;

endmodule

// ----- design/voice_allocator_with_stealing.sv -----
// ----------------------------------------------------------------------------
// voice_allocator_with_stealing
// voice pool with cut-group silencing and oldest-voice stealing
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one event per transfer: trigger, voice finished, silence
//   slot tag or silence all. rsp_ch returns exactly one result per event:
//   accepted, voice_index, stolen and the mask of voices freed by the event.
//   events are handled one at a time; req_ch.ready is high only while idle.
// sequence
//   a transfer on req_ch applies all silencing at once. a trigger with a
//   sample then walks the row of VOICES cells (32), one cell per cycle, and
//   the commit state then writes the chosen voice and loads the output
//   register, so the result shows on rsp_ch once the whole row has been
//   walked; the next event is taken after the commit. every other event
//   skips the search and goes straight to the commit state.
// reset
//   synchronous, active high: every voice is free, rsp_ch is empty, the
//   block is idle. no clearing pass is needed.
// stall
//   a result waits in the output register until rsp_ch.ready; the block
//   holds its commit until that register is free and stays not ready.
// ----------------------------------------------------------------------------
module voice_allocator_with_stealing
   import voa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   voa_req_if.sink  req_ch,
   voa_rsp_if.source rsp_ch
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   idx_type           cnt_ff, cnt_in;
   logic              req_xfer;
   logic              commit;

   // latched event
   logic              trig_ff;       // trigger with a sample, needs a voice
   logic [GRP_W-1:0]  grp_ff;
   logic [TAG_W-1:0]  tag_ff;
   time_type          start_ff;
   logic [VOICES-1:0] freed_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_accepted_ff;
   logic [OUT_IDX_W-1:0] rsp_index_ff;
   logic                 rsp_stolen_ff;
   logic [MASK_W-1:0]    rsp_mask_ff;

   cmd_type           cmd;
   cand_type          chain [VOICES+1];
   logic [VOICES-1:0] freed_now;
   logic [MASK_W-1:0] freed_out;
   logic              req_cut;
   cand_type          winner;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid & req_ch.ready;
   // commit waits for a free output register
   assign commit       = (state_ff == ST_COMMIT) & (!rsp_valid_ff | rsp_ch.ready);
   assign winner       = chain[VOICES];

   // a positive cut group silences its peers
   assign req_cut = (req_ch.operation == OP_TRIGGER) & req_ch.sample_found
                  & !req_ch.cut_group[GRP_W-1] & (req_ch.cut_group != '0);

   // broadcast to the cells: silencing at the request transfer,
   // the new voice's fields at commit
   always_comb begin
      cmd.clear_all = req_xfer & (req_ch.operation == OP_SIL_ALL);
      cmd.clear_tag = req_xfer & (req_ch.operation == OP_SIL_TAG);
      cmd.clear_fin = req_xfer & (req_ch.operation == OP_FINISHED);
      cmd.clear_cut = req_xfer & req_cut;
      cmd.tag       = req_xfer ? req_ch.slot_tag  : tag_ff;
      cmd.grp       = req_xfer ? req_ch.cut_group : grp_ff;
      cmd.fin       = req_ch.finished_voice;
      cmd.write_en  = commit & trig_ff;
      cmd.write_idx = winner.idx;
      cmd.start     = start_ff;
   end

   // the search enters the row with no candidate
   assign chain[0] = '0;

   for (genvar i = 0; i < VOICES; i++) begin : g_cell
      voa_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_index (IDX_W'(i)),
         .cmd      (cmd),
         .cand_in  (chain[i]),
         .cand_out (chain[i+1]),
         .freed    (freed_now[i])
      );
   end

   // only voices 0..31 are reported
   for (genvar j = 0; j < MASK_W; j++) begin : g_mask
      if (j < VOICES) begin : g_on
         assign freed_out[j] = freed_ff[j];
      end else begin : g_off
         assign freed_out[j] = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_xfer) begin
               if (req_ch.operation == OP_TRIGGER && req_ch.sample_found) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_SEARCH: begin
            // the row advances one cell per cycle with the state held still
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(VOICES - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // event fields, captured at the request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         trig_ff  <= (req_ch.operation == OP_TRIGGER) & req_ch.sample_found;
         grp_ff   <= req_ch.cut_group;
         tag_ff   <= req_ch.slot_tag;
         start_ff <= req_ch.current_time + TIME_BITS'(req_ch.sample_offset);
         freed_ff <= freed_now;
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_accepted_ff <= trig_ff;
         rsp_index_ff    <= trig_ff ? OUT_IDX_W'(winner.idx) : '0;
         rsp_stolen_ff   <= trig_ff & (winner.rank != RANK_FREE);
         rsp_mask_ff     <= freed_out;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.accepted    = rsp_accepted_ff;
   assign rsp_ch.voice_index = rsp_index_ff;
   assign rsp_ch.stolen      = rsp_stolen_ff;
   assign rsp_ch.freed_mask  = rsp_mask_ff;

endmodule

// ----- design/voa_checker.sv -----
// ----------------------------------------------------------------------------
// voa_checker
// port-level checks of the voice allocator, bound to the top level
// ----------------------------------------------------------------------------
module voa_checker
   import voa_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_accepted,
   input logic [OUT_IDX_W-1:0] rsp_voice_index,
   input logic                 rsp_stolen,
   input logic [MASK_W-1:0]    rsp_freed_mask
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_voice_index) && $stable(rsp_stolen)
         && $stable(rsp_freed_mask))
      else $error("result changed while stalled");

   // no voice given means no index and no steal
   a_no_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_voice_index == '0 && !rsp_stolen)
      else $error("index or steal flag without allocation");

   // one event at a time
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // after reset the result channel is empty and the block is idle
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind voice_allocator_with_stealing voa_checker u_voa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_accepted    (rsp_ch.accepted),
   .rsp_voice_index (rsp_ch.voice_index),
   .rsp_stolen      (rsp_ch.stolen),
   .rsp_freed_mask  (rsp_ch.freed_mask)
);
